// ----- rtl/dsg_pkg.sv -----
package dsg_pkg;

  localparam int OPCODE_W   = 3;
  localparam int IDX_FW     = 6;
  localparam int SIM_W      = 16;
  localparam int GAIN_W     = 22;
  localparam int TOTAL_W    = 27;
  localparam int GSIZE_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [TOTAL_W-1:0] GAIN_MAX  = TOTAL_W'(2097152);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(67108864);
  localparam logic [GSIZE_W-1:0] GSIZE_RST = GSIZE_W'(64);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_GROUND = 3'd1,
    OP_ADD    = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PARTIAL = 1'd0,
    REG_GSIZE   = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TOTAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic item_ready;
    logic res_valid;
    logic use_total;
  } ctrl_t;

endpackage

// ----- rtl/dsg_cfg_if.sv -----
interface dsg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dsg_pkg::CFG_IDX_W-1:0]  index;
  logic [dsg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dsg_item_if.sv -----
interface dsg_item_if;
  logic                         valid;
  logic                         ready;
  logic [dsg_pkg::OPCODE_W-1:0] opcode;
  logic [dsg_pkg::IDX_FW-1:0]   row_index;
  logic [dsg_pkg::IDX_FW-1:0]   col_index;
  logic [dsg_pkg::SIM_W-1:0]    similarity;
  logic                         member_flag;

  modport source (output valid, output opcode, output row_index, output col_index,
                  output similarity, output member_flag, input ready);
  modport sink (input valid, input opcode, input row_index, input col_index,
                input similarity, input member_flag, output ready);
endinterface

// ----- rtl/dsg_result_if.sv -----
interface dsg_result_if;
  logic                        valid;
  logic                        ready;
  logic [dsg_pkg::GAIN_W-1:0]  gain;
  logic [dsg_pkg::TOTAL_W-1:0] total;
  logic                        accepted;

  modport source (output valid, output gain, output total, output accepted, input ready);
  modport sink (input valid, input gain, input total, input accepted, output ready);
endinterface

// ----- rtl/disparity_sum_gain_engine_unit.sv -----
// Eligible add and query words scan one kernel row through one memory read port
// and the shared saturating adder; an add word then also passes through the total step;
// every other word gives its result in the cycle after acceptance.
// Throughput: one word at a time; the next word is taken the cycle after the result is taken.
// Reset: bitmaps, total and registers clear at once; the kernel memory is then swept to
// zero, one entry a cycle, through all 4**ceil(log2(MAX_ITEMS)) entries before the first word.
module disparity_sum_gain_engine_unit #(
  parameter int MAX_ITEMS = 64,
  parameter int FRAC_BITS = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dsg_cfg_if.sink      cfg_i,
  dsg_item_if.sink     item_i,
  dsg_result_if.source result_o
);

  import dsg_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CNT_W  = IDX_W + 1;
  localparam logic [TOTAL_W-1:0] ONE_VAL = TOTAL_W'(1) << FRAC_BITS;

  state_e                state_q, state_d;
  ctrl_t                 ctrl;
  opcode_e               op_q;
  logic [IDX_W-1:0]      item_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  pv_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [TOTAL_W-1:0]    total_q;
  logic                  acc_q;
  logic [MAX_ITEMS-1:0]  sel_q;
  logic [MAX_ITEMS-1:0]  ground_q;
  logic                  partial_q;
  logic [GSIZE_W-1:0]    gsize_q;

  logic                  item_fire;
  logic                  res_fire;
  logic                  cfg_fire;
  opcode_e               opcode;
  logic [IDX_W-1:0]      row_idx;
  logic [IDX_W-1:0]      col_idx;
  logic                  row_ok;
  logic                  col_ok;
  logic                  in_ground;
  logic                  row_eff_sel;
  logic                  eligible;
  logic                  scan_rd;
  logic                  scan_end;
  logic [IDX_W-1:0]      member;
  logic                  member_eff;
  logic                  mem_we;
  logic [SIM_W-1:0]      rdata;
  logic                  clr_done;
  logic [TOTAL_W-1:0]    k_ext;
  logic [TOTAL_W-1:0]    term;
  logic [TOTAL_W-1:0]    add_a;
  logic [TOTAL_W-1:0]    add_b;
  logic [TOTAL_W-1:0]    add_lim;
  logic [TOTAL_W-1:0]    add_y;

  assign item_fire = item_i.valid && ctrl.item_ready;
  assign res_fire  = ctrl.res_valid && result_o.ready;
  assign cfg_fire  = cfg_i.valid;
  assign cfg_i.ready = 1'b1;

  assign opcode  = opcode_e'(item_i.opcode);
  assign row_idx = IDX_W'(item_i.row_index);
  assign col_idx = IDX_W'(item_i.col_index);
  assign row_ok  = (32'(item_i.row_index) < MAX_ITEMS);
  assign col_ok  = (32'(item_i.col_index) < MAX_ITEMS);

  assign in_ground = row_ok && (partial_q ? ground_q[row_idx]
                                          : (GSIZE_W'(item_i.row_index) < gsize_q));
  assign row_eff_sel = row_ok && sel_q[row_idx] && (!partial_q || ground_q[row_idx]);
  assign eligible    = in_ground && !row_eff_sel;

  // scan: issue the read of member cnt, accumulate its data in the next cycle
  assign member     = cnt_q[IDX_W-1:0];
  assign member_eff = sel_q[member] && (!partial_q || ground_q[member]);
  assign scan_rd    = (state_q == ST_SCAN) && (32'(cnt_q) < MAX_ITEMS);
  assign scan_end   = (state_q == ST_SCAN) && (32'(cnt_q) == MAX_ITEMS);

  assign mem_we = item_fire && (opcode == OP_LOAD) && row_ok && col_ok;

  dsg_kmem #(
    .ADDR_W (ADDR_W),
    .DATA_W (SIM_W)
  ) u_kmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    ({row_idx, col_idx}),
    .wdata_i    (item_i.similarity),
    .re_i       (scan_rd),
    .raddr_i    ({member, item_q}),
    .rdata_o    (rdata),
    .clr_done_o (clr_done)
  );

  // term is one minus similarity, floored at zero
  assign k_ext = TOTAL_W'(rdata);
  assign term  = (k_ext >= ONE_VAL) ? '0 : (ONE_VAL - k_ext);

  assign add_a   = ctrl.use_total ? total_q : TOTAL_W'(gain_q);
  assign add_b   = ctrl.use_total ? TOTAL_W'(gain_q) : term;
  assign add_lim = ctrl.use_total ? TOTAL_MAX : GAIN_MAX;

  dsg_sat_add #(
    .W (TOTAL_W)
  ) u_sat_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .lim_i (add_lim),
    .y_o   (add_y)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_fire) begin
          if (((opcode == OP_ADD) || (opcode == OP_QUERY)) && eligible) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) state_d = (op_q == OP_ADD) ? ST_TOTAL : ST_OUT;
      end
      ST_TOTAL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:  ctrl.item_ready = 1'b1;
      ST_TOTAL: ctrl.use_total  = 1'b1;
      ST_OUT:   ctrl.res_valid  = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 1'b0;
      gsize_q   <= GSIZE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_PARTIAL: partial_q <= cfg_i.data[0];
        REG_GSIZE:   gsize_q   <= cfg_i.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      op_q     <= OP_LOAD;
      item_q   <= '0;
      cnt_q    <= '0;
      pv_q     <= 1'b0;
      gain_q   <= '0;
      total_q  <= '0;
      acc_q    <= 1'b0;
      sel_q    <= '0;
      ground_q <= '0;
    end else begin
      state_q <= state_d;
      pv_q    <= scan_rd && member_eff;
      if (scan_rd) cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_SCAN && pv_q) gain_q <= GAIN_W'(add_y);
      if (item_fire) begin
        op_q   <= opcode;
        item_q <= row_idx;
        cnt_q  <= '0;
        gain_q <= '0;
        acc_q  <= 1'b0;
        case (opcode)
          OP_GROUND: begin
            if (row_ok) ground_q[row_idx] <= item_i.member_flag;
          end
          OP_CLEAR: begin
            sel_q   <= '0;
            total_q <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == ST_TOTAL) begin
        total_q        <= add_y;
        sel_q[item_q]  <= 1'b1;
        acc_q          <= 1'b1;
      end
    end
  end

  assign item_i.ready      = ctrl.item_ready;
  assign result_o.valid    = ctrl.res_valid;
  assign result_o.gain     = gain_q;
  assign result_o.total    = total_q;
  assign result_o.accepted = acc_q;

endmodule

// ----- rtl/dsg_sat_add.sv -----
module dsg_sat_add #(
  parameter int W = 27
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] lim_i,
  output logic [W-1:0] y_o
);

  logic [W:0] sum;

  assign sum = {1'b0, a_i} + {1'b0, b_i};
  // clamp at the limit
  assign y_o = (sum > {1'b0, lim_i}) ? lim_i : sum[W-1:0];

endmodule

// ----- rtl/dsg_kmem.sv -----
module dsg_kmem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              clr_done_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [ADDR_W:0]   clr_cnt_q;
  logic [DATA_W-1:0] rdata_q;
  logic              clr_done;

  assign clr_done   = clr_cnt_q[ADDR_W];
  assign clr_done_o = clr_done;
  assign rdata_o    = rdata_q;

  // sweep every entry to zero once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (!clr_done) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_done) begin
      mem_q[clr_cnt_q[ADDR_W-1:0]] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule
